>>> rtl/iuct_pkg.sv
// Shared types for the interval union coverage tracker.
// No dependencies; used by iuct_merge_unit and the top level.
`default_nettype none

package iuct_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_STORE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // compare flags from the shared unit
  typedef struct packed {
    logic hit;     // operand interval overlaps the request
    logic lower;   // operand first below current merged low bound
    logic higher;  // operand last above current merged high bound
  } cmp_flags_t;

endpackage

`default_nettype wire

>>> rtl/iuct_merge_unit.sv
// Shared compare and length unit: overlap test and interval length.
// Depends on iuct_pkg (cmp_flags_t).
`default_nettype none

module iuct_merge_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic [COORD_WIDTH-1:0] req_start,
  input  wire logic [COORD_WIDTH-1:0] req_end,
  input  wire logic [COORD_WIDTH-1:0] cur_lo,
  input  wire logic [COORD_WIDTH-1:0] cur_hi,
  input  wire logic [COORD_WIDTH-1:0] op_first,
  input  wire logic [COORD_WIDTH-1:0] op_last,
  output iuct_pkg::cmp_flags_t        flags,
  output logic      [COORD_WIDTH:0]   op_len
);

  always_comb begin
    flags.hit    = (op_first <= req_end) && (op_last >= req_start);
    flags.lower  = op_first < cur_lo;
    flags.higher = op_last > cur_hi;
    // closed interval length, up to 2^COORD_WIDTH
    op_len = {1'b0, op_last} - {1'b0, op_first} + {{COORD_WIDTH{1'b0}}, 1'b1};
  end

endmodule

`default_nettype wire

>>> rtl/interval_union_coverage_tracker.sv
// Interval union coverage tracker, top level.
// Depends on iuct_pkg and iuct_merge_unit.
//
// Keeps a table of MAX_INTERVALS disjoint closed intervals and the total number
// of covered cells. Each request [range_start, range_end] is merged with every
// stored interval that overlaps it (intervals that only touch are kept apart);
// the merged interval goes into the lowest free entry and one result reports
// total_cells minus covered cells, saturated at zero. When no entry overlaps
// and the table is full, the request is dropped and table_full is set. An empty
// request (end below start) changes nothing. Timing: a non-empty request is paced
// by one table read per cycle through a single registered memory port and one
// shared compare/length unit; an empty request skips the scan. The sequencer
// returns to idle as the result is loaded, so the next request is accepted in the
// following cycle at the earliest. s_tready is high only while the sequencer is
// idle; a finished result sits in the output register, so the next request can be
// taken before the result is collected. A result that finds the output register
// still occupied waits in DONE, which stalls the sequencer until m_tready.
// The table is valid-tagged in flip-flops, so reset needs no clearing pass.
`default_nettype none

module interval_union_coverage_tracker #(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_WIDTH   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: total_cells
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] range_start, [63:32] range_end
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] uncovered_cells
  output logic [0:0]       m_tuser    // [0] table_full
);

  localparam int IW   = $clog2(MAX_INTERVALS);
  localparam int CMPW = (COORD_WIDTH + 1 > 32) ? COORD_WIDTH + 1 : 32;

  iuct_pkg::state_t state;

  logic [31:0]            total;
  logic [COORD_WIDTH:0]   covered;
  logic [MAX_INTERVALS-1:0] valid;

  // table memory
  logic [COORD_WIDTH-1:0] first_mem [MAX_INTERVALS];
  logic [COORD_WIDTH-1:0] last_mem  [MAX_INTERVALS];

  // request and merge state
  logic [COORD_WIDTH-1:0] req_start, req_end;
  logic [COORD_WIDTH-1:0] lo, hi;
  logic [IW:0]            cnt;
  logic [IW-1:0]          rd_idx;
  logic                   rd_live;
  logic [COORD_WIDTH-1:0] rd_first, rd_last;
  logic                   free_found;
  logic [IW-1:0]          free_idx;
  logic                   full;

  // shared unit operands
  logic [COORD_WIDTH-1:0] op_first, op_last;
  iuct_pkg::cmp_flags_t   flags;
  logic [COORD_WIDTH:0]   op_len;

  logic                   in_fire;
  logic [COORD_WIDTH-1:0] in_start, in_end;
  logic                   entry_v, hit, slot_free;
  logic [CMPW-1:0]        cov_ext, tot_ext;
  logic [31:0]            uncovered;

  assign s_tready = (state == iuct_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign in_start = COORD_WIDTH'(s_tdata[31:0]);
  assign in_end   = COORD_WIDTH'(s_tdata[63:32]);

  // STORE reuses the unit to size the merged interval
  always_comb begin
    if (state == iuct_pkg::ST_STORE) begin
      op_first = lo;
      op_last  = hi;
    end else begin
      op_first = rd_first;
      op_last  = rd_last;
    end
  end

  iuct_merge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .req_start (req_start),
    .req_end   (req_end),
    .cur_lo    (lo),
    .cur_hi    (hi),
    .op_first  (op_first),
    .op_last   (op_last),
    .flags     (flags),
    .op_len    (op_len)
  );

  assign entry_v   = valid[rd_idx];
  assign hit       = rd_live && entry_v && flags.hit;
  // an entry freed by this merge counts as free for slot choice
  assign slot_free = rd_live && (!entry_v || flags.hit);

  // saturated uncovered count
  always_comb begin
    cov_ext = CMPW'(covered);
    tot_ext = CMPW'(total);
    if (cov_ext >= tot_ext) uncovered = '0;
    else                    uncovered = 32'(tot_ext - cov_ext);
  end

  // table read port, one entry per cycle
  always_ff @(posedge clk) begin
    rd_first <= first_mem[cnt[IW-1:0]];
    rd_last  <= last_mem[cnt[IW-1:0]];
    rd_idx   <= cnt[IW-1:0];
    if (state == iuct_pkg::ST_STORE && free_found) begin
      first_mem[free_idx] <= lo;
      last_mem[free_idx]  <= hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) total <= '0;
    else if (cfg_we) total <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= iuct_pkg::ST_IDLE;
      covered    <= '0;
      valid      <= '0;
      cnt        <= '0;
      rd_live    <= 1'b0;
      free_found <= 1'b0;
      full       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // result taken; DONE reloads it itself when it has one ready
      if (m_tvalid && m_tready && state != iuct_pkg::ST_DONE) m_tvalid <= 1'b0;

      // merge of the entry read last cycle
      if (hit) begin
        if (flags.lower)  lo <= rd_first;
        if (flags.higher) hi <= rd_last;
        covered        <= covered - op_len;
        valid[rd_idx]  <= 1'b0;
      end
      if (slot_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end

      unique case (state)
        iuct_pkg::ST_IDLE: begin
          if (in_fire) begin
            req_start  <= in_start;
            req_end    <= in_end;
            lo         <= in_start;
            hi         <= in_end;
            cnt        <= '0;
            free_found <= 1'b0;
            full       <= 1'b0;
            if (in_end < in_start) state <= iuct_pkg::ST_DONE;
            else                   state <= iuct_pkg::ST_SCAN;
          end
        end
        iuct_pkg::ST_SCAN: begin
          rd_live <= 1'b1;
          cnt     <= cnt + 1'b1;
          if (cnt == (IW+1)'(MAX_INTERVALS - 1)) state <= iuct_pkg::ST_DRAIN;
        end
        iuct_pkg::ST_DRAIN: begin
          rd_live <= 1'b0;
          state   <= iuct_pkg::ST_STORE;
        end
        iuct_pkg::ST_STORE: begin
          if (free_found) begin
            valid[free_idx] <= 1'b1;
            covered         <= covered + op_len;
          end else begin
            full <= 1'b1;
          end
          state <= iuct_pkg::ST_DONE;
        end
        iuct_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= iuct_pkg::ST_IDLE;
          end
        end
        default: state <= iuct_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == iuct_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata    <= uncovered;
      m_tuser[0] <= full;
    end
  end

  // an idle, empty table covers nothing
  a_empty_table: assert property (@(posedge clk) disable iff (rst)
    (state == iuct_pkg::ST_IDLE && valid == '0) |-> covered == '0)
    else $error("covered count nonzero with empty table");

  // a dropped request is reported only with every entry in use
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && m_tuser[0]) |-> (&valid))
    else $error("table_full reported with a free entry");

  // the store never overwrites a live entry
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    (state == iuct_pkg::ST_STORE && free_found) |-> !valid[free_idx])
    else $error("store into a valid entry");

endmodule

`default_nettype wire
